// File: hdl/set_assoc_writeback_lru_cache_unit_assert.svh
// Assertion macros used by the checker sac_chk.
// Clock and reset are taken from the scope of the use: clk and rst_n.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_UNIT_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sac_pkg.sv
package sac_pkg;

  // Default geometry
  localparam int SETS_DEF       = 8;
  localparam int WAYS_DEF       = 5;
  localparam int LINE_BYTES_DEF = 4;
  localparam int ADDR_BITS_DEF  = 16;

  // Byte width of data and results
  localparam int DATA_W = 8;

  // Access selector codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // latch the incoming request
    logic dec_ld;   // load block number and tag
    logic set_ld;   // load set and offset, read the set's metadata row
    logic tag_ld;   // load tag compare result and the set's metadata
    logic cnt_clr;  // clear the line move counter
    logic move;     // one step of write-back and fill
    logic acc;      // access the line, write back the metadata row
    logic out_ld;   // load the result register
    logic clr_wr;   // one step of the backing memory clearing pass
  } sac_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;        // tag found in the set (valid during tag check)
    logic is_write;   // current request is a write
    logic move_last;  // last step of the line move
    logic clr_last;   // last entry of the clearing pass
  } sac_sts_t;

endpackage

// File: hdl/sac_req_if.sv
interface sac_req_if #(
  parameter int ADDR_BITS = sac_pkg::ADDR_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ADDR_BITS-1:0]       address;
  logic                       op;
  logic [sac_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output address, output op, output write_data, input ready);
  modport sink   (input valid, input address, input op, input write_data, output ready);
endinterface

// File: hdl/sac_rsp_if.sv
interface sac_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sac_pkg::DATA_W-1:0] read_data;
  logic                       hit;
  logic                       line_dirty;

  modport source (output valid, output read_data, output hit, output line_dirty, input ready);
  modport sink   (input valid, input read_data, input hit, input line_dirty, output ready);
endinterface

// File: hdl/sac_ram.sv
module sac_ram #(
  parameter int WIDTH = sac_pkg::DATA_W,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

// File: hdl/sac_ctrl.sv
module sac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sac_pkg::sac_sts_t sts,
  output sac_pkg::sac_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SET  = 3'd3;
  localparam logic [2:0] S_TAG  = 3'd4;
  localparam logic [2:0] S_MOVE = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec_ld = 1'b1;
        state_nxt  = S_SET;
      end
      S_SET: begin
        cmd.set_ld = 1'b1;
        state_nxt  = S_TAG;
      end
      S_TAG: begin
        cmd.tag_ld  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.hit ? S_ACC : S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (sts.move_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.is_write ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/sac_dpath.sv
module sac_dpath #(
  parameter int SETS       = sac_pkg::SETS_DEF,
  parameter int WAYS       = sac_pkg::WAYS_DEF,
  parameter int LINE_BYTES = sac_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = sac_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sac_pkg::sac_cmd_t          cmd,
  output sac_pkg::sac_sts_t          sts,
  input  logic [ADDR_BITS-1:0]       in_address,
  input  logic                       in_op,
  input  logic [sac_pkg::DATA_W-1:0] in_write_data,
  output logic [sac_pkg::DATA_W-1:0] out_read_data,
  output logic                       out_hit,
  output logic                       out_line_dirty
);

  localparam int DW      = sac_pkg::DATA_W;
  localparam int OFF_W   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W   = WAY_W;
  localparam int SPAN    = LINE_BYTES * SETS;
  localparam int TAG_MAX = ((1 << ADDR_BITS) - 1) / SPAN;
  localparam int TAG_W   = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;
  localparam int LDEPTH  = SETS * WAYS * LINE_BYTES;
  localparam int LIDX_W  = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int CNT_W   = $clog2(LINE_BYTES + 1);
  localparam int MDEPTH  = 1 << ADDR_BITS;
  localparam int META_W  = WAYS * (TAG_W + 2 + AGE_W);
  localparam int PROD_W  = 2 * ADDR_BITS + 1;
  // Reciprocals for exact division of an ADDR_BITS-bit value by a constant
  localparam int K1 = ADDR_BITS + $clog2(LINE_BYTES);
  localparam int K2 = ADDR_BITS + $clog2(SPAN);
  localparam longint unsigned M1_L =
    ((longint'(1) << K1) + longint'(LINE_BYTES) - 1) / longint'(LINE_BYTES);
  localparam longint unsigned M2_L =
    ((longint'(1) << K2) + longint'(SPAN) - 1) / longint'(SPAN);
  localparam logic [ADDR_BITS:0] M1 = M1_L[ADDR_BITS:0];
  localparam logic [ADDR_BITS:0] M2 = M2_L[ADDR_BITS:0];

  typedef logic [WAYS-1:0][TAG_W-1:0] tags_t;
  typedef logic [WAYS-1:0][AGE_W-1:0] ages_t;

  // Request registers
  logic [ADDR_BITS-1:0] addr_r;
  logic                 op_r;
  logic [DW-1:0]        wdata_r;
  logic [ADDR_BITS-1:0] blk_r;
  logic [TAG_W-1:0]     tag_r;
  logic [SET_W-1:0]     set_r;
  logic [OFF_W-1:0]     off_r;

  // Metadata of the current set and lookup result
  tags_t                tags_r;
  logic [WAYS-1:0]      valid_r;
  logic [WAYS-1:0]      dirty_r;
  ages_t                age_r;
  logic                 hit_r;
  logic [WAY_W-1:0]     way_r;
  logic                 wb_r;
  logic [TAG_W-1:0]     vtag_r;

  // Control counters and row valid bits
  logic [CNT_W-1:0]     cnt_r;
  logic [ADDR_BITS-1:0] clr_r;
  logic [SETS-1:0]      rowv_r;

  // Result register
  logic [DW-1:0]        out_data_r;
  logic                 out_hit_r;
  logic                 out_dirty_r;

  // Address split
  logic [PROD_W-1:0]    prod1, prod2;
  logic [SET_W-1:0]     set_c;
  logic [OFF_W-1:0]     off_c;

  assign prod1 = PROD_W'(addr_r) * PROD_W'(M1);
  assign prod2 = PROD_W'(addr_r) * PROD_W'(M2);
  assign off_c = OFF_W'(addr_r - ADDR_BITS'(blk_r * LINE_BYTES));
  assign set_c = SET_W'(blk_r - ADDR_BITS'(tag_r * SETS));

  // Metadata store, one row per set
  logic [META_W-1:0]    meta_rd, meta_wd;
  tags_t                rd_tags, cur_tags, new_tags;
  logic [WAYS-1:0]      rd_valid, rd_dirty, cur_valid, cur_dirty, new_valid, new_dirty;
  ages_t                rd_age, cur_age, new_age;

  assign {rd_tags, rd_valid, rd_dirty, rd_age} = meta_rd;
  assign meta_wd = {new_tags, new_valid, new_dirty, new_age};

  sac_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (set_r),
    .wdata (meta_wd),
    .re    (cmd.set_ld),
    .raddr (set_c),
    .rdata (meta_rd)
  );

  // Tag compare and victim choice; a row never written reads as its reset value
  logic             hit_c, rv;
  logic [WAY_W-1:0] hit_way, vic_way;

  always_comb begin
    rv      = rowv_r[set_r];
    hit_c   = 1'b0;
    hit_way = '0;
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      cur_tags[w]  = rv ? rd_tags[w] : '0;
      cur_valid[w] = rv & rd_valid[w];
      cur_dirty[w] = rv & rd_dirty[w];
      cur_age[w]   = rv ? rd_age[w] : AGE_W'(WAYS - 1 - w);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur_valid[w] && (cur_tags[w] == tag_r)) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (cur_age[w] == AGE_W'(WAYS - 1)) begin
        vic_way = WAY_W'(w);
      end
    end
  end

  // Metadata update: LRU ages, tag, valid and dirty of the accessed way
  logic [AGE_W-1:0] hit_age;

  always_comb begin
    new_tags  = tags_r;
    new_valid = valid_r;
    new_dirty = dirty_r;
    hit_age   = age_r[way_r];
    for (int w = 0; w < WAYS; w++) begin
      if (hit_r) begin
        new_age[w] = (age_r[w] < hit_age) ? AGE_W'(age_r[w] + 1'b1) : age_r[w];
      end else begin
        new_age[w] = (age_r[w] == AGE_W'(WAYS - 1)) ? '0 : AGE_W'(age_r[w] + 1'b1);
      end
    end
    if (hit_r) begin
      new_age[way_r] = '0;
    end else begin
      new_tags[way_r]  = tag_r;
      new_valid[way_r] = 1'b1;
      new_dirty[way_r] = 1'b0;
    end
    if (op_r == sac_pkg::OP_WRITE) begin
      new_dirty[way_r] = 1'b1;
    end
  end

  // Line move addressing: read byte cnt, write byte cnt-1, the byte read in the previous cycle
  logic [LIDX_W-1:0]    line_base;
  logic [OFF_W-1:0]     rd_off, wr_off;
  logic [ADDR_BITS-1:0] new_base, old_base;
  logic                 move_rd, move_wr;

  assign line_base = LIDX_W'((set_r * WAYS + way_r) * LINE_BYTES);
  assign rd_off    = OFF_W'(cnt_r);
  assign wr_off    = OFF_W'(cnt_r - 1'b1);
  assign new_base  = ADDR_BITS'(addr_r - ADDR_BITS'(off_r));
  assign old_base  = ADDR_BITS'(vtag_r * SPAN + set_r * LINE_BYTES);
  assign move_rd   = cmd.move && (cnt_r != CNT_W'(LINE_BYTES));
  assign move_wr   = cmd.move && (cnt_r != '0);

  // Line data store
  logic [LIDX_W-1:0] line_raddr, line_waddr;
  logic [DW-1:0]     line_rd, line_wdata, mem_rd;
  logic              line_we, line_re;

  assign line_raddr = cmd.move ? LIDX_W'(line_base + LIDX_W'(rd_off))
                               : LIDX_W'(line_base + LIDX_W'(off_r));
  assign line_waddr = cmd.move ? LIDX_W'(line_base + LIDX_W'(wr_off))
                               : LIDX_W'(line_base + LIDX_W'(off_r));
  assign line_wdata = cmd.move ? mem_rd : wdata_r;
  assign line_we    = move_wr || (cmd.acc && (op_r == sac_pkg::OP_WRITE));
  assign line_re    = move_rd || cmd.acc;

  sac_ram #(.WIDTH(DW), .DEPTH(LDEPTH)) u_lines (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rd)
  );

  // Backing memory: clearing pass, write-back and fill
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_we;

  assign mem_we    = cmd.clr_wr || (move_wr && wb_r);
  assign mem_waddr = cmd.clr_wr ? clr_r : ADDR_BITS'(old_base + ADDR_BITS'(wr_off));
  assign mem_wdata = cmd.clr_wr ? '0 : line_rd;
  assign mem_raddr = ADDR_BITS'(new_base + ADDR_BITS'(rd_off));

  sac_ram #(.WIDTH(DW), .DEPTH(MDEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (move_rd),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
      clr_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= ADDR_BITS'(clr_r + 1'b1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.move) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      if (cmd.acc) begin
        rowv_r[set_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r  <= in_address;
      op_r    <= in_op;
      wdata_r <= in_write_data;
    end
    if (cmd.dec_ld) begin
      blk_r <= ADDR_BITS'(prod1 >> K1);
      tag_r <= TAG_W'(prod2 >> K2);
    end
    if (cmd.set_ld) begin
      set_r <= set_c;
      off_r <= off_c;
    end
    if (cmd.tag_ld) begin
      tags_r  <= cur_tags;
      valid_r <= cur_valid;
      dirty_r <= cur_dirty;
      age_r   <= cur_age;
      hit_r   <= hit_c;
      way_r   <= hit_c ? hit_way : vic_way;
      wb_r    <= ~hit_c & cur_valid[vic_way] & cur_dirty[vic_way];
      vtag_r  <= cur_tags[vic_way];
    end
    if (cmd.out_ld) begin
      out_data_r  <= line_rd;
      out_hit_r   <= hit_r;
      out_dirty_r <= hit_r & dirty_r[way_r];
    end
  end

  assign sts.hit       = hit_c;
  assign sts.is_write  = (op_r == sac_pkg::OP_WRITE);
  assign sts.move_last = (cnt_r == CNT_W'(LINE_BYTES));
  assign sts.clr_last  = &clr_r;

  assign out_read_data  = out_data_r;
  assign out_hit        = out_hit_r;
  assign out_line_dirty = out_dirty_r;

endmodule

// File: hdl/set_assoc_writeback_lru_cache_unit.sv
// Byte-wide set-associative write-back cache with LRU replacement, in front of
// a backing memory of 2^ADDR_BITS bytes held inside the block.
// in_ch carries one request per handshake: address, op (read/write) and a byte.
// out_ch carries one result per read request: read_data, hit and line_dirty.
// A write request produces no result.
// Requests are handled one at a time. Each goes through decode, set
// lookup and tag check; a miss then moves the line (write-back and fill),
// and the access follows. A read then loads its result register.
// A dirty victim costs nothing extra: its write-back runs in the same pass
// as the fill, both through the byte-wide backing memory.
// After reset the block clears all 2^ADDR_BITS bytes of the backing memory,
// one byte per cycle; in_ch.ready stays low during that pass.
// Cache lines come out of reset empty with their reset LRU order.
// A result waits in an output register while out_ch.ready is low; the next
// request is still accepted and processed, and holds only at its own result.
module set_assoc_writeback_lru_cache_unit #(
  parameter int SETS       = sac_pkg::SETS_DEF,
  parameter int WAYS       = sac_pkg::WAYS_DEF,
  parameter int LINE_BYTES = sac_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = sac_pkg::ADDR_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sac_req_if.sink   in_ch,
  sac_rsp_if.source out_ch
);

  sac_pkg::sac_cmd_t cmd;
  sac_pkg::sac_sts_t sts;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sac_dpath #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_address     (in_ch.address),
    .in_op          (in_ch.op),
    .in_write_data  (in_ch.write_data),
    .out_read_data  (out_ch.read_data),
    .out_hit        (out_ch.hit),
    .out_line_dirty (out_ch.line_dirty)
  );

endmodule

// File: hdl/sac_chk.sv
`include "set_assoc_writeback_lru_cache_unit_assert.svh"

module sac_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sac_pkg::DATA_W-1:0] out_read_data,
  input logic                       out_hit,
  input logic                       out_line_dirty
);

  // A stalled result stays offered
  `SAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `SAC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_read_data) && $stable(out_hit) && $stable(out_line_dirty), "result changed while stalled")

  // A miss always reports a freshly filled, clean line
  `SAC_ASSERT_SAME(a_miss_clean, out_valid && !out_hit, !out_line_dirty, "read miss reported dirty line")

  // Requests are handled one at a time: no back-to-back acceptance
  `SAC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while busy")

endmodule

bind set_assoc_writeback_lru_cache_unit sac_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_hit        (out_ch.hit),
  .out_line_dirty (out_ch.line_dirty)
);
